### hw/rtl/smac_pkg.sv
// ----------------------------------------------------------------------------
// Slouch monitor package
// Shared widths, reset values, register indexes, codes and the verdict type
// that passes from the posture tracker to the top level.
// ----------------------------------------------------------------------------
package smac_pkg;

    localparam int DISTANCE_BITS_DEF = 12;
    localparam int STREAK_BITS_DEF   = 8;

    localparam int COUNT_BITS    = 8;
    localparam int COOL_BITS     = 8;
    localparam int BREAK_BITS    = 16;
    localparam int SCORE_BITS    = 7;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;

    localparam int THRESHOLD_RESET = 80;
    localparam int TRIGGER_RESET   = 3;
    localparam int CLEAR_RESET     = 2;
    localparam int COOLDOWN_RESET  = 18;
    localparam int BREAK_RESET     = 720;

    localparam int SCORE_FULL  = 100;
    localparam int SCORE_SPAN  = 150;
    // floor(x / 3) == (x * 683) >> 11 for every x below 2048.
    localparam int RECIP_THIRD = 683;
    localparam int RECIP_SHIFT = 11;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLEAR     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COOLDOWN  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BREAK     = 3'd4;

    typedef enum logic [1:0] {
        ST_UNCAL      = 2'd0,
        ST_SENSOR_ERR = 2'd1,
        ST_MONITOR    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ALERT_NONE   = 2'd0,
        ALERT_SLOUCH = 2'd1,
        ALERT_BREAK  = 2'd2
    } alert_t;

    typedef struct packed {
        status_t status;
        logic    taken;
        logic    slouching;
        alert_t  alert;
    } verdict_t;

endpackage

### hw/rtl/smac_if.sv
// ----------------------------------------------------------------------------
// Slouch monitor channels
// Valid/ready channels for the sample items, the result items and the
// configuration writes.
// ----------------------------------------------------------------------------
interface smac_in_if #(
    parameter int DISTANCE_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic [DISTANCE_BITS-1:0] distance_mm;
    logic                     calibrate;
    logic [DISTANCE_BITS-1:0] baseline_candidate_mm;

    modport source (output valid, output distance_mm, output calibrate,
                    output baseline_candidate_mm, input ready);
    modport sink (input valid, input distance_mm, input calibrate,
                  input baseline_candidate_mm, output ready);
endinterface

interface smac_out_if #(
    parameter int DISTANCE_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic                     calibration_taken;
    logic [DISTANCE_BITS-1:0] excess_mm;
    logic [6:0]               score;
    logic                     is_slouching;
    logic [1:0]               alert;

    modport source (output valid, output status, output calibration_taken,
                    output excess_mm, output score, output is_slouching,
                    output alert, input ready);
    modport sink (input valid, input status, input calibration_taken,
                  input excess_mm, input score, input is_slouching,
                  input alert, output ready);
endinterface

interface smac_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/smac_score.sv
// ----------------------------------------------------------------------------
// Slouch monitor score
// Distance above baseline and the posture score derived from it.
// ----------------------------------------------------------------------------
module smac_score
    import smac_pkg::*;
#(
    parameter int DISTANCE_BITS = DISTANCE_BITS_DEF
) (
    input  logic [DISTANCE_BITS-1:0] distance_mm,
    input  logic [DISTANCE_BITS-1:0] baseline_mm,
    output logic [DISTANCE_BITS-1:0] excess_mm,
    output logic [SCORE_BITS-1:0]    score
);

    localparam logic [DISTANCE_BITS-1:0] SPAN = DISTANCE_BITS'(SCORE_SPAN);
    localparam int PROD_BITS = 19;

    logic [8:0]           twice;
    logic [PROD_BITS-1:0] prod;
    logic [7:0]           third;

    assign excess_mm = (distance_mm > baseline_mm) ? (distance_mm - baseline_mm) : '0;

    // Below the span the excess fits in eight bits, so 2 * excess / 3 is a
    // short multiply by a reciprocal.
    assign twice = {excess_mm[7:0], 1'b0};
    assign prod  = PROD_BITS'(twice) * PROD_BITS'(RECIP_THIRD);
    assign third = prod[RECIP_SHIFT +: 8];

    always_comb
    begin
        if (excess_mm >= SPAN)
        begin
            score = '0;
        end
        else
        begin
            score = SCORE_BITS'(8'(SCORE_FULL) - third);
        end
    end

endmodule

### hw/rtl/smac_tracker.sv
// ----------------------------------------------------------------------------
// Slouch monitor posture tracker
// Configuration registers, baseline, streaks, slouching flag, cooldown and
// break counter, with the decision logic for one item.
// ----------------------------------------------------------------------------
module smac_tracker
    import smac_pkg::*;
#(
    parameter int DISTANCE_BITS = DISTANCE_BITS_DEF,
    parameter int STREAK_BITS   = STREAK_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    smac_cfg_if.sink                 cfg,
    input  logic                     commit,
    input  logic [DISTANCE_BITS-1:0] distance_mm,
    input  logic                     calibrate,
    input  logic [DISTANCE_BITS-1:0] candidate_mm,
    input  logic [DISTANCE_BITS-1:0] excess_mm,
    output logic [DISTANCE_BITS-1:0] baseline_mm,
    output verdict_t                 verdict
);

    localparam int CMP_BITS = (STREAK_BITS > COUNT_BITS) ? STREAK_BITS : COUNT_BITS;
    localparam logic [STREAK_BITS-1:0] STREAK_MAX = '1;
    localparam logic [BREAK_BITS-1:0]  BREAK_MAX  = '1;

    logic [DISTANCE_BITS-1:0] thresh_reg;
    logic [COUNT_BITS-1:0]    trigger_reg;
    logic [COUNT_BITS-1:0]    clear_reg;
    logic [COOL_BITS-1:0]     cool_load_reg;
    logic [BREAK_BITS-1:0]    break_loops_reg;

    logic [DISTANCE_BITS-1:0] baseline_reg, baseline_next;
    logic                     calibrated_reg, calibrated_next;
    logic                     flag_reg, flag_next;
    logic [STREAK_BITS-1:0]   slouch_reg, slouch_next;
    logic [STREAK_BITS-1:0]   upright_reg, upright_next;
    logic [BREAK_BITS-1:0]    break_reg, break_next;
    logic [COOL_BITS-1:0]     cool_reg, cool_next;

    logic                     take;
    logic                     flag_m;
    logic [STREAK_BITS-1:0]   slouch_m, upright_m;
    logic [BREAK_BITS-1:0]    break_m, break_inc;
    logic [COOL_BITS-1:0]     cool_m, cool_dec;

    assign cfg.ready = 1'b1;

    // A successful calibration clears the monitoring state before this item
    // is judged against the new baseline.
    assign take      = calibrate && (candidate_mm != '0);
    assign flag_m    = take ? 1'b0 : flag_reg;
    assign slouch_m  = take ? '0 : slouch_reg;
    assign upright_m = take ? '0 : upright_reg;
    assign break_m   = take ? '0 : break_reg;
    assign cool_m    = take ? '0 : cool_reg;

    assign baseline_next   = take ? candidate_mm : baseline_reg;
    assign calibrated_next = take || calibrated_reg;
    assign baseline_mm     = baseline_next;

    assign cool_dec  = (cool_m != '0) ? (cool_m - 1'b1) : cool_m;
    assign break_inc = (break_m != BREAK_MAX) ? (break_m + 1'b1) : break_m;

    always_comb
    begin
        flag_next       = flag_m;
        slouch_next     = slouch_m;
        upright_next    = upright_m;
        break_next      = break_m;
        cool_next       = cool_m;
        verdict.status  = ST_UNCAL;
        verdict.alert   = ALERT_NONE;
        verdict.taken   = take;

        if (!calibrated_next)
        begin
            verdict.status = ST_UNCAL;
        end
        else if (distance_mm == '0)
        begin
            verdict.status = ST_SENSOR_ERR;
        end
        else
        begin
            verdict.status = ST_MONITOR;

            if (excess_mm >= thresh_reg)
            begin
                slouch_next  = (slouch_m != STREAK_MAX) ? (slouch_m + 1'b1) : slouch_m;
                upright_next = '0;
            end
            else
            begin
                upright_next = (upright_m != STREAK_MAX) ? (upright_m + 1'b1) : upright_m;
                slouch_next  = '0;
            end

            if (!flag_m && (CMP_BITS'(slouch_next) >= CMP_BITS'(trigger_reg)))
            begin
                flag_next = 1'b1;
            end
            else if (flag_m && (CMP_BITS'(upright_next) >= CMP_BITS'(clear_reg)))
            begin
                flag_next = 1'b0;
            end

            cool_next = cool_dec;
            if (flag_next)
            begin
                break_next = '0;
                if (cool_dec == '0)
                begin
                    verdict.alert = ALERT_SLOUCH;
                    cool_next     = cool_load_reg;
                end
            end
            else
            begin
                break_next = break_inc;
                if ((break_inc >= break_loops_reg) && (cool_dec == '0))
                begin
                    verdict.alert = ALERT_BREAK;
                    break_next    = '0;
                    cool_next     = cool_load_reg;
                end
            end
        end

        verdict.slouching = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg      <= DISTANCE_BITS'(THRESHOLD_RESET);
            trigger_reg     <= COUNT_BITS'(TRIGGER_RESET);
            clear_reg       <= COUNT_BITS'(CLEAR_RESET);
            cool_load_reg   <= COOL_BITS'(COOLDOWN_RESET);
            break_loops_reg <= BREAK_BITS'(BREAK_RESET);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_THRESHOLD: thresh_reg      <= cfg.data[DISTANCE_BITS-1:0];
                CFG_TRIGGER:   trigger_reg     <= cfg.data[COUNT_BITS-1:0];
                CFG_CLEAR:     clear_reg       <= cfg.data[COUNT_BITS-1:0];
                CFG_COOLDOWN:  cool_load_reg   <= cfg.data[COOL_BITS-1:0];
                CFG_BREAK:     break_loops_reg <= cfg.data[BREAK_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg   <= '0;
            calibrated_reg <= 1'b0;
            flag_reg       <= 1'b0;
            slouch_reg     <= '0;
            upright_reg    <= '0;
            break_reg      <= '0;
            cool_reg       <= '0;
        end
        else if (commit)
        begin
            baseline_reg   <= baseline_next;
            calibrated_reg <= calibrated_next;
            flag_reg       <= flag_next;
            slouch_reg     <= slouch_next;
            upright_reg    <= upright_next;
            break_reg      <= break_next;
            cool_reg       <= cool_next;
        end
    end

endmodule

### hw/rtl/slouch_monitor_with_alert_cooldown.sv
// ----------------------------------------------------------------------------
// Slouch monitor with alert cooldown
// One item in per monitoring loop, one result item out per item.
// ----------------------------------------------------------------------------
// Channels: sample carries the filtered distance, a calibration request and
// the candidate baseline; result carries status, calibration_taken, excess,
// score, the slouching flag and the alert code; cfg writes the five
// registers by index (threshold, trigger, clear, cooldown, break loops) and
// is always ready. Registers must be written only while no item is in flight;
// the block does not enforce this. An accepted item sits in the input
// register, where the tracker judges it against the held state, and its
// result item is loaded into the result register when the item advances,
// that is when the result register is empty or being taken.
// Throughput is one item per cycle while the receiver does not stall; the
// state update of one item is committed as it leaves the input register,
// so the next item follows straight behind it.
// When the receiver stalls, the result register holds its item and the
// input register holds the next; sample.ready drops only when both are full.
// Reset clears the baseline, the calibrated flag and all monitoring state,
// loads the register defaults and empties both registers.
// ----------------------------------------------------------------------------
module slouch_monitor_with_alert_cooldown
    import smac_pkg::*;
#(
    parameter int DISTANCE_BITS = DISTANCE_BITS_DEF,
    parameter int STREAK_BITS   = STREAK_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    smac_in_if.sink   sample,
    smac_out_if.source result,
    smac_cfg_if.sink  cfg
);

    logic                     s1_valid_reg;
    logic [DISTANCE_BITS-1:0] s1_dist_reg;
    logic                     s1_cal_reg;
    logic [DISTANCE_BITS-1:0] s1_cand_reg;

    logic                     res_valid_reg;
    status_t                  res_status_reg;
    logic                     res_taken_reg;
    logic [DISTANCE_BITS-1:0] res_excess_reg;
    logic [SCORE_BITS-1:0]    res_score_reg;
    logic                     res_slouch_reg;
    alert_t                   res_alert_reg;

    logic                     advance;
    logic [DISTANCE_BITS-1:0] baseline_mm;
    logic [DISTANCE_BITS-1:0] excess_mm;
    logic [SCORE_BITS-1:0]    score;
    verdict_t                 verdict;

    assign advance      = s1_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;

    smac_score #(
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_score (
        .distance_mm (s1_dist_reg),
        .baseline_mm (baseline_mm),
        .excess_mm   (excess_mm),
        .score       (score)
    );

    smac_tracker #(
        .DISTANCE_BITS (DISTANCE_BITS),
        .STREAK_BITS   (STREAK_BITS)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .commit       (advance),
        .distance_mm  (s1_dist_reg),
        .calibrate    (s1_cal_reg),
        .candidate_mm (s1_cand_reg),
        .excess_mm    (excess_mm),
        .baseline_mm  (baseline_mm),
        .verdict      (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_dist_reg <= sample.distance_mm;
            s1_cal_reg  <= sample.calibrate;
            s1_cand_reg <= sample.baseline_candidate_mm;
        end
        if (advance)
        begin
            res_status_reg <= verdict.status;
            res_taken_reg  <= verdict.taken;
            res_slouch_reg <= verdict.slouching;
            res_alert_reg  <= verdict.alert;
            // Excess and score mean something only while monitoring.
            if (verdict.status == ST_MONITOR)
            begin
                res_excess_reg <= excess_mm;
                res_score_reg  <= score;
            end
            else
            begin
                res_excess_reg <= '0;
                res_score_reg  <= '0;
            end
        end
    end

    assign result.valid             = res_valid_reg;
    assign result.status            = res_status_reg;
    assign result.calibration_taken = res_taken_reg;
    assign result.excess_mm         = res_excess_reg;
    assign result.score             = res_score_reg;
    assign result.is_slouching      = res_slouch_reg;
    assign result.alert             = res_alert_reg;

    a_alert_needs_monitor : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (res_alert_reg == ALERT_NONE || res_status_reg == ST_MONITOR))
        else $error("alert raised outside monitoring");

    a_idle_fields_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && res_status_reg != ST_MONITOR) |->
            (res_excess_reg == '0 && res_score_reg == '0))
        else $error("excess or score set without a monitoring result");

    a_score_range : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (res_score_reg <= SCORE_BITS'(SCORE_FULL)))
        else $error("score above full marks");

    a_item_held : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("item dropped from the input register");

endmodule

### dv/slouch_monitor_with_alert_cooldown_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slouch monitor testbench
// Drives monitoring loops and calibration requests into the slouch monitor,
// predicts every result item from its own model of the posture state, and
// compares the results field by field under random gaps and stalls.
// ----------------------------------------------------------------------------
module slouch_monitor_with_alert_cooldown_test;
    import smac_pkg::*;

    localparam int DW            = DISTANCE_BITS_DEF;
    localparam int DIST_TOP      = (1 << DW) - 1;
    localparam int STREAK_TOP    = (1 << STREAK_BITS_DEF) - 1;
    localparam int BREAK_TOP     = (1 << BREAK_BITS) - 1;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_OFF      = 50;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct {
        status_t         status;
        logic            taken;
        logic [DW-1:0]   excess;
        logic [6:0]      score;
        logic            slouching;
        alert_t          alert;
    } loop_result_t;

    logic clk = 1'b0;
    logic rst_n;

    smac_in_if #(.DISTANCE_BITS(DW))  sample_ch ();
    smac_out_if #(.DISTANCE_BITS(DW)) result_ch ();
    smac_cfg_if                       cfg_ch ();

    slouch_monitor_with_alert_cooldown uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Register copies held by the posture model.
    logic [DW-1:0]         cfg_threshold;
    logic [COUNT_BITS-1:0] cfg_trigger;
    logic [COUNT_BITS-1:0] cfg_clear;
    logic [COOL_BITS-1:0]  cfg_cooldown;
    logic [BREAK_BITS-1:0] cfg_break;

    // Posture state held by the model.
    logic [DW-1:0]              trk_baseline;
    logic                       trk_calibrated;
    logic                       trk_slouching;
    logic [STREAK_BITS_DEF-1:0] trk_slouch_run;
    logic [STREAK_BITS_DEF-1:0] trk_upright_run;
    logic [BREAK_BITS-1:0]      trk_break_count;
    logic [COOL_BITS-1:0]       trk_cooldown;

    loop_result_t pending_verdicts[$];
    int           errors = 0;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;
    int           rx_hold_req = 0;
    int           rx_stall = 0;
    int           idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic loop_result_t judge_loop(input logic [DW-1:0] dist_mm, input logic cal,
                                                input logic [DW-1:0] cand);
        loop_result_t v;
        int           excess;
        v.status    = ST_UNCAL;
        v.taken     = 1'b0;
        v.excess    = '0;
        v.score     = '0;
        v.alert     = ALERT_NONE;
        if (cal && cand != 0)
        begin
            trk_baseline    = cand;
            trk_calibrated  = 1'b1;
            trk_slouching   = 1'b0;
            trk_slouch_run  = '0;
            trk_upright_run = '0;
            trk_break_count = '0;
            trk_cooldown    = '0;
            v.taken         = 1'b1;
        end
        if (!trk_calibrated)
            v.status = ST_UNCAL;
        else if (dist_mm == 0)
            v.status = ST_SENSOR_ERR;
        else
        begin
            v.status = ST_MONITOR;
            excess   = (dist_mm > trk_baseline) ? int'(dist_mm) - int'(trk_baseline) : 0;
            v.excess = DW'(excess);
            if (excess == 0)
                v.score = 7'(SCORE_FULL);
            else if (excess >= SCORE_SPAN)
                v.score = '0;
            else
                v.score = 7'(SCORE_FULL - (excess * SCORE_FULL) / SCORE_SPAN);

            if (excess >= int'(cfg_threshold))
            begin
                if (trk_slouch_run != STREAK_TOP)
                    trk_slouch_run++;
                trk_upright_run = '0;
            end
            else
            begin
                if (trk_upright_run != STREAK_TOP)
                    trk_upright_run++;
                trk_slouch_run = '0;
            end
            if (!trk_slouching && trk_slouch_run >= cfg_trigger)
                trk_slouching = 1'b1;
            else if (trk_slouching && trk_upright_run >= cfg_clear)
                trk_slouching = 1'b0;

            // The cooldown ticks down before either alert is considered.
            if (trk_cooldown != 0)
                trk_cooldown--;
            if (trk_slouching)
            begin
                trk_break_count = '0;
                if (trk_cooldown == 0)
                begin
                    v.alert      = ALERT_SLOUCH;
                    trk_cooldown = cfg_cooldown;
                end
            end
            else
            begin
                if (trk_break_count != BREAK_TOP)
                    trk_break_count++;
                if (trk_break_count >= cfg_break && trk_cooldown == 0)
                begin
                    v.alert         = ALERT_BREAK;
                    trk_break_count = '0;
                    trk_cooldown    = cfg_cooldown;
                end
            end
        end
        v.slouching = trk_slouching;
        return v;
    endfunction

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Result side: random stalls, a requested hold-off, and the comparison.
    always @(posedge clk)
    begin
        loop_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: result item with no expectation, expected none, got status %0d",
                         $time, result_ch.status);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                report_field("status", want.status, result_ch.status);
                report_field("calibration_taken", want.taken, result_ch.calibration_taken);
                report_field("excess_mm", want.excess, result_ch.excess_mm);
                report_field("score", want.score, result_ch.score);
                report_field("is_slouching", want.slouching, result_ch.is_slouching);
                report_field("alert", want.alert, result_ch.alert);
            end
        end
        if (rx_hold_req > 0)
        begin
            rx_stall    = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_stall > 0)
        begin
            result_ch.ready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            if (rx_idle_on)
                rx_stall = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic offer_loop(input logic [DW-1:0] dist_mm, input logic cal,
                              input logic [DW-1:0] cand);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid                 <= 1'b1;
        sample_ch.distance_mm           <= dist_mm;
        sample_ch.calibrate             <= cal;
        sample_ch.baseline_candidate_mm <= cand;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pending_verdicts.push_back(judge_loop(dist_mm, cal, cand));
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_THRESHOLD: cfg_threshold = value[DW-1:0];
            CFG_TRIGGER:   cfg_trigger   = value[COUNT_BITS-1:0];
            CFG_CLEAR:     cfg_clear     = value[COUNT_BITS-1:0];
            CFG_COOLDOWN:  cfg_cooldown  = value[COOL_BITS-1:0];
            CFG_BREAK:     cfg_break     = value[BREAK_BITS-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stops offering items and waits until every result item has come back.
    task automatic settle_idle();
        sample_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A distance on the requested side of the threshold for the current baseline.
    function automatic logic [DW-1:0] pick_distance(input bit slouched);
        int room;
        int lo;
        int hi;
        int ex;
        room = DIST_TOP - int'(trk_baseline);
        if (slouched)
        begin
            if (int'(cfg_threshold) > room)
                return DW'(DIST_TOP);
            lo = cfg_threshold;
            hi = (room - lo > 160) ? lo + 160 : room;
            ex = $urandom_range(hi, lo);
            if ($urandom_range(0, 9) == 0)
                ex = $urandom_range(room, lo);
            return DW'(int'(trk_baseline) + ex);
        end
        if (cfg_threshold == 0)
            return (trk_baseline == 0) ? DW'(1) : trk_baseline;
        if (trk_baseline > 1 && $urandom_range(0, 3) == 0)
            return DW'($urandom_range(int'(trk_baseline) - 1, 1));
        hi = int'(cfg_threshold) - 1;
        if (hi > room)
            hi = room;
        ex = $urandom_range(hi, (hi > 160) ? hi - 160 : 0);
        if ($urandom_range(0, 7) == 0)
            ex = $urandom_range((hi < 5) ? hi : 5, 0);
        return DW'(int'(trk_baseline) + ex);
    endfunction

    task automatic send_streak(input int n, input bit slouched);
        for (int k = 0; k < n; k++)
            offer_loop(pick_distance(slouched), 1'b0, DW'($urandom));
    endtask

    task automatic run_phase(input int n);
        int sent;
        int r;
        int len;
        logic [DW-1:0] cand;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                r = $urandom_range(0, 19);
                if (r < 5)
                    cand = '0;
                else if (r < 7)
                    cand = DW'(1);
                else if (r < 9)
                    cand = DW'(DIST_TOP);
                else
                    cand = DW'($urandom_range(100, 2000));
                offer_loop(DW'($urandom_range(0, DIST_TOP)), 1'b1, cand);
                sent++;
            end
            else if (r < 8)
            begin
                offer_loop('0, 1'b0, DW'($urandom));
                sent++;
            end
            else if (r < 14)
            begin
                offer_loop(DW'($urandom), 1'b0, DW'($urandom));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 12);
                send_streak(len, $urandom_range(0, 1));
                sent += len;
            end
        end
    endtask

    task automatic randomise_registers();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            cfg_write(CFG_THRESHOLD, {4'($urandom), 12'd0});
        else if (r == 1)
            cfg_write(CFG_THRESHOLD, {4'($urandom), 12'(DIST_TOP)});
        else
            cfg_write(CFG_THRESHOLD, {4'($urandom), 12'($urandom_range(20, 300))});
        cfg_write(CFG_TRIGGER, {8'($urandom), 8'($urandom_range(0, 8))});
        cfg_write(CFG_CLEAR, {8'($urandom), 8'($urandom_range(0, 8))});
        cfg_write(CFG_COOLDOWN, {8'($urandom), 8'($urandom_range(0, 12))});
        cfg_write(CFG_BREAK, 16'($urandom_range(0, 40)));
    endtask

    task automatic test_before_calibration();
        offer_loop(DW'(500), 1'b0, '0);
        offer_loop('0, 1'b0, DW'(DIST_TOP));
        // A calibration request with a zero candidate is a failed calibration.
        offer_loop(DW'(DIST_TOP), 1'b1, '0);
        offer_loop(DW'(1), 1'b0, DW'(1000));
    endtask

    task automatic test_calibration_and_scores();
        offer_loop(DW'(DIST_TOP), 1'b1, DW'(DIST_TOP));
        offer_loop(DW'(DIST_TOP), 1'b1, DW'(1));
        offer_loop('0, 1'b1, DW'(1000));
        offer_loop(DW'(1000), 1'b0, '0);
        offer_loop(DW'(999), 1'b0, '0);
        offer_loop(DW'(1001), 1'b0, '0);
        offer_loop(DW'(1002), 1'b0, '0);
        // Three loops at or past the default threshold enter slouching.
        offer_loop(DW'(1149), 1'b0, '0);
        offer_loop(DW'(1150), 1'b0, '0);
        offer_loop(DW'(1151), 1'b0, '0);
        offer_loop('0, 1'b0, '0);
        offer_loop(DW'(1079), 1'b0, '0);
        offer_loop(DW'(1080), 1'b0, '0);
        offer_loop(DW'(1000), 1'b0, '0);
        offer_loop(DW'(1000), 1'b0, '0);
        offer_loop(DW'(1000), 1'b0, '0);
    endtask

    task automatic test_backpressure();
        settle_idle();
        tx_idle_on  = 1'b0;
        rx_hold_req = HOLD_OFF;
        send_streak(20, $urandom_range(0, 1));
        settle_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_register_extremes();
        settle_idle();
        // Every loop slouched, the slouch streak runs into saturation.
        cfg_write(CFG_THRESHOLD, 16'hF000);
        cfg_write(CFG_TRIGGER, 16'hA5FF);
        cfg_write(CFG_CLEAR, 16'h00FF);
        cfg_write(CFG_COOLDOWN, 16'h5AFF);
        cfg_write(CFG_BREAK, 16'h0001);
        offer_loop(DW'(1000), 1'b1, DW'(1000));
        send_streak(STREAK_TOP + 5, 1'b1);
        settle_idle();

        // Zero counts act as always met, and a zero break length alerts freely.
        cfg_write(CFG_THRESHOLD, 16'h0FFF);
        cfg_write(CFG_TRIGGER, 16'hFF00);
        cfg_write(CFG_CLEAR, 16'h0000);
        cfg_write(CFG_COOLDOWN, 16'hFF00);
        cfg_write(CFG_BREAK, 16'h0000);
        offer_loop(DW'(1500), 1'b1, DW'(1200));
        run_phase(30);
        send_streak(20, 1'b0);
        settle_idle();

        // Writes to unused indexes must leave every register alone.
        for (int i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++)
            cfg_write(CFG_INDEX_BITS'(i), 16'hFFFF);
        run_phase(20);
        settle_idle();
    endtask

    task automatic test_random_loops();
        for (int p = 0; p < 3; p++)
        begin
            settle_idle();
            randomise_registers();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            offer_loop(DW'($urandom_range(1, DIST_TOP)), 1'b1, DW'($urandom_range(200, 1500)));
            run_phase(40);
        end
        settle_idle();
    endtask

    // A long upright run with no cooldown raises the break reminder repeatedly.
    task automatic test_break_reminder();
        settle_idle();
        cfg_write(CFG_THRESHOLD, 16'd100);
        cfg_write(CFG_TRIGGER, 16'd1);
        cfg_write(CFG_CLEAR, 16'd1);
        cfg_write(CFG_COOLDOWN, 16'd0);
        cfg_write(CFG_BREAK, 16'd25);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        offer_loop(DW'(1000), 1'b1, DW'(1000));
        send_streak(60, 1'b0);
        settle_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n                           = 1'b0;
        sample_ch.valid                 = 1'b0;
        sample_ch.distance_mm           = '0;
        sample_ch.calibrate             = 1'b0;
        sample_ch.baseline_candidate_mm = '0;
        result_ch.ready                 = 1'b0;
        cfg_ch.valid                    = 1'b0;
        cfg_ch.index                    = '0;
        cfg_ch.data                     = '0;

        cfg_threshold   = DW'(THRESHOLD_RESET);
        cfg_trigger     = COUNT_BITS'(TRIGGER_RESET);
        cfg_clear       = COUNT_BITS'(CLEAR_RESET);
        cfg_cooldown    = COOL_BITS'(COOLDOWN_RESET);
        cfg_break       = BREAK_BITS'(BREAK_RESET);
        trk_baseline    = '0;
        trk_calibrated  = 1'b0;
        trk_slouching   = 1'b0;
        trk_slouch_run  = '0;
        trk_upright_run = '0;
        trk_break_count = '0;
        trk_cooldown    = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_calibration();
        test_calibration_and_scores();
        test_backpressure();
        test_register_extremes();
        test_random_loops();
        test_break_reminder();

        settle_idle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
